/* src/fault_tolerant_mesh_route_select_assert.svh */
// Assertion macros for the mesh route select block.
`ifndef FAULT_TOLERANT_MESH_ROUTE_SELECT_ASSERT_SVH
`define FAULT_TOLERANT_MESH_ROUTE_SELECT_ASSERT_SVH

// Checked only outside reset.
`define FTMRS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define FTMRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ftmrs_pkg.sv */
package ftmrs_pkg;

    localparam int COORD_W     = 4;
    localparam int ARRIVAL_W   = 3;
    localparam int PORT_CODE_W = 3;
    localparam int HEIGHT_W    = 5;
    localparam int MAX_DIM     = 16;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 8;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(8);
    localparam logic [HEIGHT_W-1:0] MAX_HEIGHT   = HEIGHT_W'(MAX_DIM);

    typedef enum logic [PORT_CODE_W-1:0] {
        PORT_NORTH = 3'd0,
        PORT_EAST  = 3'd1,
        PORT_SOUTH = 3'd2,
        PORT_WEST  = 3'd3,
        PORT_NONE  = 3'd4,
        PORT_HERE  = 3'd5
    } port_t;

    typedef struct packed {
        logic [COORD_W-1:0]   cur_x;
        logic [COORD_W-1:0]   cur_y;
        logic [COORD_W-1:0]   dst_x;
        logic [COORD_W-1:0]   dst_y;
        logic [ARRIVAL_W-1:0] arrival_port;
        logic                 north_good;
        logic                 east_good;
        logic                 south_good;
        logic                 west_good;
    } route_req_t;

endpackage

/* src/ftmrs_route_logic.sv */
module ftmrs_route_logic
    import ftmrs_pkg::*;
(
    input  route_req_t          req,
    input  logic [HEIGHT_W-1:0] mesh_height,
    output port_t               out_port
);

    logic               x_pos;
    logic               x_neg;
    logic               y_pos;
    logic               y_neg;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [HEIGHT_W-1:0] h_eff;
    logic               south_edge;
    logic               west_edge;
    logic               arr_pos;

    always_comb
    begin
        x_pos = req.dst_x > req.cur_x;
        x_neg = req.dst_x < req.cur_x;
        y_pos = req.dst_y > req.cur_y;   // destination further south
        y_neg = req.dst_y < req.cur_y;
        dx = x_pos ? (req.dst_x - req.cur_x) : (req.cur_x - req.dst_x);
        dy = y_pos ? (req.dst_y - req.cur_y) : (req.cur_y - req.dst_y);
        h_eff = (mesh_height > MAX_HEIGHT) ? MAX_HEIGHT : mesh_height;
        south_edge = ({1'b0, req.cur_y} + HEIGHT_W'(1)) == h_eff;
        west_edge = req.cur_x == '0;
        arr_pos = (req.arrival_port == PORT_SOUTH) || (req.arrival_port == PORT_WEST);

        priority if (!x_pos && !x_neg && !y_pos && !y_neg)
        begin
            out_port = PORT_HERE;
        end
        else if (x_pos && y_neg)                        // NE
        begin
            if (!req.north_good && !req.east_good)
                out_port = PORT_NONE;
            else if (dy > dx)
                out_port = req.north_good ? PORT_NORTH : PORT_EAST;
            else
                out_port = req.east_good ? PORT_EAST : PORT_NORTH;
        end
        else if (x_pos && !y_pos)                       // E
        begin
            if ((dx == COORD_W'(1)) || ((dx == COORD_W'(2)) && req.east_good)
                || south_edge || arr_pos)
                out_port = PORT_EAST;
            else
                out_port = req.south_good ? PORT_SOUTH : PORT_EAST;
        end
        else if (x_pos || y_pos && !x_neg)              // SE, S
        begin
            out_port = req.south_good ? PORT_SOUTH : PORT_WEST;
        end
        else if (!x_neg)                                // N
        begin
            if ((dy == COORD_W'(1)) || ((dy == COORD_W'(2)) && req.north_good)
                || west_edge || arr_pos)
                out_port = PORT_NORTH;
            else
                out_port = req.west_good ? PORT_WEST : PORT_NORTH;
        end
        else if (!y_pos)                                // NW, W
        begin
            out_port = req.west_good ? PORT_WEST : PORT_SOUTH;
        end
        else                                            // SW
        begin
            if (!req.west_good && !req.south_good)
                out_port = PORT_NONE;
            else if (dx >= dy)
                out_port = req.west_good ? PORT_WEST : PORT_SOUTH;
            else
                out_port = req.south_good ? PORT_SOUTH : PORT_WEST;
        end
    end

endmodule

/* src/fault_tolerant_mesh_route_select.sv */
// Path from input beat to result beat: input register, route logic, output register.
// One beat per cycle unless the result side stalls; the route decision is one pass of shallow compare logic.
// Backpressure on the result side stalls both stages; inputs keep flowing while a slot is free.
// Reset (rst_n low, asynchronous): both stages empty, mesh_height returns to 8.
module fault_tolerant_mesh_route_select
    import ftmrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration: mesh_height
    input  logic                  cfg_wen,
    input  logic [HEIGHT_W-1:0]   cfg_wdata,

    // input beats
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, low bit up: cur_x[3:0], cur_y[7:4], dst_x[11:8], dst_y[15:12],
    // arrival_port[18:16], north_good[19], east_good[20], south_good[21],
    // west_good[22], zero pad[23]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,

    // result beats
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, low bit up: out_port[2:0], zero pad[7:3]
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    logic [HEIGHT_W-1:0] mesh_height_reg;

    // stage 1: registered request
    route_req_t req_reg;
    route_req_t req_next;
    logic       s1_valid_reg;

    // stage 2: registered result
    port_t      port_reg;
    port_t      port_next;
    logic       s2_valid_reg;

    logic       s2_load;
    logic       s1_load;

    // Stage 2 can take a new value when empty or when its beat leaves now.
    assign s2_load       = !s2_valid_reg || m_axis_tready;
    // Stage 1 frees when empty or when it moves into stage 2.
    assign s_axis_tready = !s1_valid_reg || s2_load;
    assign s1_load       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        req_next.cur_x        = s_axis_tdata[3:0];
        req_next.cur_y        = s_axis_tdata[7:4];
        req_next.dst_x        = s_axis_tdata[11:8];
        req_next.dst_y        = s_axis_tdata[15:12];
        req_next.arrival_port = s_axis_tdata[18:16];
        req_next.north_good   = s_axis_tdata[19];
        req_next.east_good    = s_axis_tdata[20];
        req_next.south_good   = s_axis_tdata[21];
        req_next.west_good    = s_axis_tdata[22];
    end

    ftmrs_route_logic u_route (
        .req         (req_reg),
        .mesh_height (mesh_height_reg),
        .out_port    (port_next)
    );

    // Configuration register; the user must write it only while the pipe is idle, the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mesh_height_reg <= HEIGHT_RESET;
        else if (cfg_wen)
            mesh_height_reg <= cfg_wdata;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                s1_valid_reg <= s_axis_tvalid;
            if (s2_load)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (s1_load)
            req_reg <= req_next;
        if (s2_load && s1_valid_reg)
            port_reg <= port_next;
    end

    assign m_axis_tvalid = s2_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-PORT_CODE_W){1'b0}}, port_reg};

endmodule

/* src/ftmrs_checker.sv */
`include "fault_tolerant_mesh_route_select_assert.svh"

module ftmrs_checker
    import ftmrs_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // A held result beat keeps its value.
    `FTMRS_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

    // Results are only real port codes with clean padding.
    `FTMRS_ASSERT(a_out_code, clk, rst_n, m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:PORT_CODE_W] == '0) && (m_axis_tdata[PORT_CODE_W-1:0] <= PORT_HERE), "bad out_port code")

    // The input side stalls only when the result side is backed up.
    `FTMRS_ASSERT(a_stall_cause, clk, rst_n, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

    // Leaving reset, the pipe is empty and ready.
    `FTMRS_ASSERT_ALWAYS(a_reset_empty, clk, $rose(rst_n) |-> !m_axis_tvalid && s_axis_tready, "pipe not empty after reset")

endmodule

bind fault_tolerant_mesh_route_select ftmrs_checker u_ftmrs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* bench/tb_fault_tolerant_mesh_route_select.sv */
module tb_fault_tolerant_mesh_route_select;
    timeunit 1ns;
    timeprecision 1ps;

    import ftmrs_pkg::*;

    // Pipeline is two stages deep; SETTLE_CYCLES sets the pauses before a height
    // write and at the end of the run.
    localparam int LATENCY         = 2;
    localparam int SETTLE_CYCLES   = LATENCY + 3;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 205;
    localparam int PHASE_COUNT     = 8;
    localparam int LONG_HOLD       = 80;
    localparam int SHOWN_FAILS     = 10;

    // Arrival codes beyond the four neighbor ports (same encoding as port_t).
    localparam logic [ARRIVAL_W-1:0] ARR_LOCAL = 3'd4;
    localparam logic [ARRIVAL_W-1:0] ARR_SPARE = 3'd7;

    // Neighbor-good masks, {west, south, east, north}.
    localparam logic [3:0] GOOD_N   = 4'b0001;
    localparam logic [3:0] GOOD_E   = 4'b0010;
    localparam logic [3:0] GOOD_S   = 4'b0100;
    localparam logic [3:0] GOOD_W   = 4'b1000;
    localparam logic [3:0] ALL_GOOD = 4'b1111;
    localparam logic [3:0] NO_GOOD  = 4'b0000;

    // Scoreboard: predicts the chosen port for each accepted request beat
    // and checks result beats against the oldest prediction.
    class route_scoreboard;
        logic [PORT_CODE_W-1:0] expected_ports[$];
        int unsigned            fail_count;

        function logic [PORT_CODE_W-1:0] predict_port(logic [S_TDATA_W-1:0] beat,
                                                      logic [HEIGHT_W-1:0] rows);
            int cx, cy, tx, ty, ddx, ddy, dx, dy, h;
            logic [ARRIVAL_W-1:0]   arr;
            logic                   ng, eg, sg, wg;
            logic                   south_edge, west_edge, from_positive;
            logic [PORT_CODE_W-1:0] p;
            cx  = int'(beat[3:0]);
            cy  = int'(beat[7:4]);
            tx  = int'(beat[11:8]);
            ty  = int'(beat[15:12]);
            arr = beat[18:16];
            ng  = beat[19];
            eg  = beat[20];
            sg  = beat[21];
            wg  = beat[22];
            ddx = tx - cx;
            ddy = ty - cy;
            dx  = (ddx < 0) ? -ddx : ddx;
            dy  = (ddy < 0) ? -ddy : ddy;
            // height is clamped to the largest mesh; zero means no south edge
            h = (rows > MAX_HEIGHT) ? MAX_DIM : int'(rows);
            south_edge    = (cy + 1 == h);
            west_edge     = (cx == 0);
            from_positive = (arr == PORT_SOUTH) || (arr == PORT_WEST);

            if (ddx == 0 && ddy == 0)
                p = PORT_HERE;
            else if (ddx > 0 && ddy < 0)
            begin
                // northeast
                if (!ng && !eg)
                    p = PORT_NONE;
                else if (dy > dx)
                    p = ng ? PORT_NORTH : PORT_EAST;
                else
                    p = eg ? PORT_EAST : PORT_NORTH;
            end
            else if (ddx > 0 && ddy == 0)
            begin
                // due east
                if (dx == 1 || (dx == 2 && eg) || south_edge || from_positive)
                    p = PORT_EAST;
                else
                    p = sg ? PORT_SOUTH : PORT_EAST;
            end
            else if (ddx > 0)
                p = sg ? PORT_SOUTH : PORT_WEST;       // southeast
            else if (ddx == 0 && ddy > 0)
                p = sg ? PORT_SOUTH : PORT_WEST;       // due south
            else if (ddx == 0)
            begin
                // due north
                if (dy == 1 || (dy == 2 && ng) || west_edge || from_positive)
                    p = PORT_NORTH;
                else
                    p = wg ? PORT_WEST : PORT_NORTH;
            end
            else if (ddy <= 0)
                p = wg ? PORT_WEST : PORT_SOUTH;       // northwest, due west
            else
            begin
                // southwest
                if (!wg && !sg)
                    p = PORT_NONE;
                else if (dx >= dy)
                    p = wg ? PORT_WEST : PORT_SOUTH;
                else
                    p = sg ? PORT_SOUTH : PORT_WEST;
            end
            return p;
        endfunction

        function void note_request(logic [S_TDATA_W-1:0] beat, logic [HEIGHT_W-1:0] rows);
            expected_ports.insert(expected_ports.size(), predict_port(beat, rows));
        endfunction

        function void report_fail(string what, int want, int got);
            fail_count++;
            if (fail_count <= SHOWN_FAILS)
                $display("%0t: %s: expected out_port %0d, got %0d", $time, what, want, got);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            logic [PORT_CODE_W-1:0] want;
            if (expected_ports.size() == 0)
                report_fail("result beat with no request pending", -1, int'(beat[2:0]));
            else
            begin
                want = expected_ports.pop_front();
                if (beat[PORT_CODE_W-1:0] !== want)
                    report_fail("route choice wrong", int'(want), int'(beat[2:0]));
            end
        endfunction

        function int pending();
            return expected_ports.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wen;
    logic [HEIGHT_W-1:0]   cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // cur_x, cur_y, dst_x, dst_y, arrival_port, north/east/south/west good, pad
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // out_port, pad
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    route_scoreboard       scoreboard = new();
    logic [HEIGHT_W-1:0]   mesh_rows;           // shadow of the height register
    int unsigned           send_idle_pct;
    int unsigned           recv_idle_pct;
    int unsigned           hold_req;            // long hold-off request to the receiver
    int unsigned           hold_left;
    int unsigned           quiet_cycles = 0;

    fault_tolerant_mesh_route_select uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Beats are sampled in the active region right after the edge, so the
    // values seen are the ones the block saw at that edge.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            scoreboard.note_request(s_axis_tdata, mesh_rows);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            scoreboard.check_result(m_axis_tdata);
    end

    // Result side: random stalls, plus an occasional long hold-off that lets
    // the pipeline fill up and push back on the request side.
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: too long without any beat on either side ends the run.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("fault_tolerant_mesh_route_select: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [S_TDATA_W-1:0] pack_request(
        input logic [COORD_W-1:0]   cx,
        input logic [COORD_W-1:0]   cy,
        input logic [COORD_W-1:0]   tx,
        input logic [COORD_W-1:0]   ty,
        input logic [ARRIVAL_W-1:0] arr,
        input logic [3:0]           good
    );
        return {1'b0, good, arr, ty, tx, cy, cx};
    endfunction

    // Random request biased toward the interesting spots: the south edge row,
    // short hops (at most two steps), and same-row / same-column targets.
    function automatic logic [S_TDATA_W-1:0] random_request(input int rows);
        logic [COORD_W-1:0] cx, cy, tx, ty;
        cx = COORD_W'($urandom_range(15));
        if (rows >= 1 && $urandom_range(3) == 0)
            cy = COORD_W'(rows - 1);
        else
            cy = COORD_W'($urandom_range(15));
        case ($urandom_range(3))
            0:
            begin
                tx = COORD_W'($urandom_range(15));
                ty = COORD_W'($urandom_range(15));
            end
            1:
            begin
                tx = COORD_W'(int'(cx) + int'($urandom_range(4)) - 2);
                ty = COORD_W'(int'(cy) + int'($urandom_range(4)) - 2);
            end
            2:
            begin
                tx = COORD_W'($urandom_range(15));
                ty = cy;
            end
            default:
            begin
                tx = cx;
                ty = COORD_W'($urandom_range(15));
            end
        endcase
        return pack_request(cx, cy, tx, ty, ARRIVAL_W'($urandom_range(7)),
                            4'($urandom_range(15)));
    endfunction

    // Offer one request beat, with random idle cycles in front of it;
    // returns in the time step of the accepting edge with tvalid still high.
    task automatic send_beat(input logic [S_TDATA_W-1:0] beat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Height changes only once the pipeline has drained; the first edge lets
    // the monitor record the last accepted request.
    task automatic write_height(input logic [HEIGHT_W-1:0] value);
        @(posedge clk);
        while (scoreboard.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        mesh_rows  = value;
    endtask

    // Heights per random phase: extremes, out-of-range values, and zero.
    logic [HEIGHT_W-1:0] phase_rows [PHASE_COUNT] = '{5'd16, 5'd1, 5'd0, 5'd31,
                                                      5'd17, 5'd8, 5'd12, 5'd3};

    initial
    begin
        int rows;
        rst_n         = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        mesh_rows     = HEIGHT_RESET;
        send_idle_pct = 19;
        recv_idle_pct = 57;
        hold_req      = 0;
        hold_left     = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset height of 8 (row 7 is the south edge).
        send_beat(pack_request(0, 0, 0, 0, PORT_NORTH, NO_GOOD));         // at destination
        send_beat(pack_request(15, 15, 15, 15, ARR_SPARE, ALL_GOOD));     // at destination
        send_beat(pack_request(3, 5, 5, 2, ARR_LOCAL, GOOD_S | GOOD_W));  // NE, no route
        send_beat(pack_request(2, 4, 4, 2, ARR_LOCAL, GOOD_N));           // NE diag, east bad
        send_beat(pack_request(2, 6, 3, 1, PORT_WEST, ALL_GOOD));         // NE steep
        send_beat(pack_request(2, 6, 3, 1, ARR_LOCAL, GOOD_E));           // NE steep, north bad
        send_beat(pack_request(0, 15, 15, 0, ARR_LOCAL, ALL_GOOD));       // NE corner to corner
        send_beat(pack_request(4, 3, 5, 3, ARR_LOCAL, GOOD_S));           // E one hop, east bad
        send_beat(pack_request(4, 3, 6, 3, ARR_LOCAL, ALL_GOOD));         // E two hops
        send_beat(pack_request(4, 3, 6, 3, PORT_NORTH, GOOD_S | GOOD_N)); // E two hops, east bad
        send_beat(pack_request(0, 7, 9, 7, ARR_LOCAL, ALL_GOOD));         // E on south edge
        send_beat(pack_request(0, 2, 9, 2, PORT_WEST, ALL_GOOD));         // E from west
        send_beat(pack_request(0, 2, 15, 2, ARR_SPARE, ALL_GOOD));        // E, spare arrival code
        send_beat(pack_request(1, 2, 8, 2, PORT_EAST, GOOD_N | GOOD_E | GOOD_W)); // E, south bad
        send_beat(pack_request(6, 5, 6, 4, ARR_LOCAL, NO_GOOD));          // N one hop
        send_beat(pack_request(6, 5, 6, 3, ARR_LOCAL, ALL_GOOD));         // N two hops
        send_beat(pack_request(0, 12, 0, 2, ARR_LOCAL, GOOD_S));          // N on west edge
        send_beat(pack_request(6, 12, 6, 2, PORT_SOUTH, ALL_GOOD));       // N from south
        send_beat(pack_request(6, 12, 6, 2, ARR_LOCAL, ALL_GOOD));        // N, detour west
        send_beat(pack_request(6, 12, 6, 2, PORT_NORTH, GOOD_N));         // N, west bad
        send_beat(pack_request(9, 9, 3, 4, ARR_LOCAL, GOOD_S));           // NW, west bad
        send_beat(pack_request(2, 2, 8, 9, ARR_LOCAL, GOOD_E));           // SE, south bad
        send_beat(pack_request(15, 0, 0, 15, ARR_LOCAL, GOOD_N | GOOD_E)); // SW, no route
        send_beat(pack_request(9, 2, 3, 5, ARR_LOCAL, GOOD_S));           // SW wide, west bad
        send_beat(pack_request(9, 2, 7, 9, ARR_LOCAL, ALL_GOOD));         // SW tall
        s_axis_tvalid <= 1'b0;

        // Random phases: sender-light / receiver-heavy stalls first, then
        // swapped, then none, with one long result-side hold-off.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_height(phase_rows[p]);
            if (p < 3)
            begin
                send_idle_pct = 19;
                recv_idle_pct = 57;
            end
            else if (p < 6)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 6)
                hold_req = LONG_HOLD;
            rows = (phase_rows[p] > MAX_HEIGHT) ? MAX_DIM : int'(phase_rows[p]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_beat(random_request(rows));
            s_axis_tvalid <= 1'b0;
        end

        @(posedge clk);
        while (scoreboard.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (scoreboard.fail_count == 0 && scoreboard.pending() == 0)
            $display("fault_tolerant_mesh_route_select: match");
        else
            $display("fault_tolerant_mesh_route_select: mismatch");
        $finish;
    end

endmodule
